/* rtl/heightmap_triangle_height_query_assert.svh */
// Assertion macros used by the block's top module.
`ifndef HEIGHTMAP_TRIANGLE_HEIGHT_QUERY_ASSERT_SVH
`define HEIGHTMAP_TRIANGLE_HEIGHT_QUERY_ASSERT_SVH
`define HTQ_ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define HTQ_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

/* rtl/htq_pkg.sv */
package htq_pkg;
  localparam int unsigned MaxSide = 256;
  localparam logic [1:0] RegOriginX = 2'd0;
  localparam logic [1:0] RegOriginZ = 2'd1;
  localparam logic [1:0] RegVertexCount = 2'd2;
  localparam logic [1:0] RegInvCell = 2'd3;
  localparam logic KindWrite = 1'b0;
  localparam logic KindQuery = 1'b1;
endpackage

/* rtl/heightmap_triangle_height_query.sv */
// Terrain height lookup with triangle interpolation.
// Input channel s_axis: kind in tuser, other fields in tdata. A write item
// stores one grid height and yields no result; a query item yields one
// result on m_axis carrying the height in tdata and the inside flag in tuser.
// Configuration is written through cfg_valid/cfg_ready/cfg_index/cfg_data;
// the user must write it only while the block is idle, which the block does not enforce; it is always ready.
// The pipeline has five stages: offset subtract, four 33x13 partial products,
// partial sum with cell check, corner read from four banked memories, and
// blend, then the output register. One request is accepted in every cycle
// while the receiver does not stall.
// When the receiver stalls, the whole pipeline holds, and s_axis_tready
// drops only when the output register holds an unaccepted result.
// Reset clears the valid bits and sets the configuration registers to their
// defaults; the height grid is not cleared and must be written before it is read.
// Each corner comes from one of four banks selected by column and row parity,
// so all three corners of a triangle are read in the same cycle.
module heightmap_triangle_height_query (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: cell_x[7:0], cell_z[15:8], height_value[31:16], world_x[63:32],
  // world_z[95:64]
  input  logic [95:0] s_axis_tdata,
  // tuser: kind
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: height[15:0]
  output logic [15:0] m_axis_tdata,
  // tuser: inside_res
  output logic        m_axis_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  localparam int MAX_SIDE = htq_pkg::MaxSide;
  localparam int CW = $clog2(MAX_SIDE);
  localparam int HW = (CW > 1) ? CW - 1 : 1;
  localparam int BD = (MAX_SIDE / 2) * (MAX_SIDE / 2);
  localparam int BA = 2 * HW;

  logic signed [31:0] origin_x, origin_z;
  logic [8:0] vertex_count;
  logic [23:0] inv_cell_size;
  logic [10:0] vc_clamp;
  logic [10:0] cells;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= '0;
      origin_z <= '0;
      vertex_count <= 9'd256;
      inv_cell_size <= 24'd65536;
    end else if (cfg_valid) begin
      case (cfg_index)
        htq_pkg::RegOriginX: origin_x <= cfg_data;
        htq_pkg::RegOriginZ: origin_z <= cfg_data;
        htq_pkg::RegVertexCount: vertex_count <= cfg_data[8:0];
        htq_pkg::RegInvCell: inv_cell_size <= cfg_data[23:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    vc_clamp = 11'(vertex_count);
    if (vc_clamp < 11'd2) vc_clamp = 11'd2;
    if (vc_clamp > 11'(MAX_SIDE)) vc_clamp = 11'(MAX_SIDE);
    cells = vc_clamp - 11'd1;
  end

  logic adv;
  logic v1, v2, v3, v4, v5;
  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // Stage 1: local offsets, write request capture.
  logic k1;
  logic signed [32:0] lx, lz;
  logic [7:0] wcx, wcz;
  logic [15:0] whv;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= s_axis_tvalid;
    if (adv) begin
      k1 <= s_axis_tuser;
      lx <= 33'($signed(s_axis_tdata[63:32])) - 33'(origin_x);
      lz <= 33'($signed(s_axis_tdata[95:64])) - 33'(origin_z);
      wcx <= s_axis_tdata[7:0];
      wcz <= s_axis_tdata[15:8];
      whv <= s_axis_tdata[31:16];
    end
  end

  // Stage 2: split products (high and low 12 bits of the scale).
  logic signed [45:0] pxh, pzh, pxl, pzl;
  logic q2;
  logic wv2;
  logic [7:0] wcx2, wcz2;
  logic [15:0] whv2;
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      wv2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1 && k1 == htq_pkg::KindQuery;
      wv2 <= v1 && k1 == htq_pkg::KindWrite;
    end
    if (adv) begin
      pxh <= 46'(lx * $signed({1'b0, inv_cell_size[23:12]}));
      pzh <= 46'(lz * $signed({1'b0, inv_cell_size[23:12]}));
      pxl <= 46'(lx * $signed({1'b0, inv_cell_size[11:0]}));
      pzl <= 46'(lz * $signed({1'b0, inv_cell_size[11:0]}));
      wcx2 <= wcx;
      wcz2 <= wcz;
      whv2 <= whv;
    end
  end
  assign q2 = v2;

  // Stage 3: full scaled value, cell range check, bank addresses.
  logic signed [57:0] sx, sz;
  logic ins3;
  logic [CW-1:0] gx3, gz3;
  logic [15:0] fx3, fz3;
  logic wv3;
  logic [7:0] wcx3, wcz3;
  logic [15:0] whv3;
  always_comb begin
    sx = (58'(pxh) <<< 12) + 58'(pxl);
    sz = (58'(pzh) <<< 12) + 58'(pzl);
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      wv3 <= 1'b0;
    end else if (adv) begin
      v3 <= q2;
      wv3 <= wv2;
    end
    if (adv) begin
      ins3 <= !sx[57] && !sz[57] && (sx[56:32] < 25'(cells))
              && (sz[56:32] < 25'(cells));
      gx3 <= sx[32+CW-1:32];
      gz3 <= sz[32+CW-1:32];
      fx3 <= sx[31:16];
      fz3 <= sz[31:16];
      wcx3 <= wcx2;
      wcz3 <= wcz2;
      whv3 <= whv2;
    end
  end

  // Banks by (column parity, row parity); addresses for the four corners.
  logic [CW:0] x1, z1;
  logic [BA-1:0] ra [4];
  logic upper3;
  assign x1 = {1'b0, gx3} + 1'b1;
  assign z1 = {1'b0, gz3} + 1'b1;
  assign upper3 = ({1'b0, fx3} + {1'b0, fz3}) > 17'd65536;
  always_comb begin
    for (int b = 0; b < 4; b++) begin
      logic [CW-1:0] cx, cz;
      cx = (gx3[0] == b[1]) ? gx3 : x1[CW-1:0];
      cz = (gz3[0] == b[0]) ? gz3 : z1[CW-1:0];
      ra[b] = {cx[CW-1:1], cz[CW-1:1]};
    end
  end

  // Writes land in the stage that reads, so requests see the grid in order.
  logic wr_en;
  logic [BA-1:0] wa;
  assign wr_en = adv && wv3
                 && 32'(wcx3) < 32'(MAX_SIDE) && 32'(wcz3) < 32'(MAX_SIDE);
  assign wa = {wcx3[CW-1:1], wcz3[CW-1:1]};
  logic [15:0] rd [4];
  for (genvar b = 0; b < 4; b++) begin : g_bank
    htq_ram #(.Width(16), .Depth(BD)) u_ram (
      .clk(clk),
      .we(wr_en && wcx3[0] == b[1] && wcz3[0] == b[0]),
      .waddr(wa), .wdata(whv3),
      .re(adv), .raddr(ra[b]), .rdata(rd[b]));
  end

  // Stage 4: data from the banks.
  logic ins4, upper4;
  logic px4, pz4;
  logic [15:0] fx4, fz4;
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (adv) v4 <= v3;
    if (adv) begin
      ins4 <= ins3; upper4 <= upper3;
      px4 <= gx3[0]; pz4 <= gz3[0];
      fx4 <= fx3; fz4 <= fz3;
    end
  end
  logic [15:0] h00, h10, h01, h11, ha, hb, hc;
  always_comb begin
    h00 = rd[{px4, pz4}];
    h10 = rd[{!px4, pz4}];
    h01 = rd[{px4, !pz4}];
    h11 = rd[{!px4, !pz4}];
    ha = upper4 ? h10 : h00;
    hb = upper4 ? h11 : h10;
    hc = h01;
  end

  // Stage 5: products in the blend unit.
  logic ins5;
  logic signed [15:0] hres;
  htq_blend u_blend (
    .clk(clk), .en(adv), .upper(upper4), .fx(fx4), .fz(fz4),
    .ha(ha), .hb(hb), .hc(hc), .height(hres));
  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (adv) v5 <= v4;
    if (adv) ins5 <= ins4;
  end

  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (adv) m_axis_tvalid <= v5;
    if (adv) begin
      m_axis_tdata <= ins5 ? hres : 16'd0;
      m_axis_tuser <= ins5;
    end
  end

  `include "heightmap_triangle_height_query_assert.svh"
  `HTQ_ASSERT_NEXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `HTQ_ASSERT_IMPL(a_zero, clk, rst, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == 16'd0)
  `HTQ_ASSERT_NEXT(a_stable, clk, rst, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
  `HTQ_ASSERT_IMPL(a_rdy, clk, rst, !m_axis_tvalid, s_axis_tready)
endmodule

/* rtl/htq_ram.sv */
module htq_ram #(
  parameter int Width = 16,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

/* rtl/htq_blend.sv */
module htq_blend (
  input  logic               clk,
  input  logic               en,
  input  logic               upper,
  input  logic [15:0]        fx,
  input  logic [15:0]        fz,
  input  logic signed [15:0] ha,
  input  logic signed [15:0] hb,
  input  logic signed [15:0] hc,
  output logic signed [15:0] height
);
  logic [16:0] wa, wb, wc;
  logic signed [34:0] pa, pb, pc;
  logic signed [36:0] sum;
  always_comb begin
    if (upper) begin
      wa = 17'd65536 - {1'b0, fz};
      wb = {1'b0, fx} + {1'b0, fz} - 17'd65536;
      wc = 17'd65536 - {1'b0, fx};
    end else begin
      wa = 17'd65536 - {1'b0, fx} - {1'b0, fz};
      wb = {1'b0, fx};
      wc = {1'b0, fz};
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      pa <= 35'(ha * $signed({1'b0, wa}));
      pb <= 35'(hb * $signed({1'b0, wb}));
      pc <= 35'(hc * $signed({1'b0, wc}));
    end
  end
  assign sum = 37'(pa) + 37'(pb) + 37'(pc);
  assign height = sum[31:16];
endmodule

/* sim/htq_checker.sv */
`timescale 1ns / 100ps
module htq_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,
  input  logic        m_axis_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending
);
  typedef struct packed {
    logic [15:0] height;
    logic        in_grid;
  } height_result_t;

  logic signed [31:0] org_x, org_z;
  logic [8:0]         vtx_count;
  logic [23:0]        inv_cell;
  logic signed [15:0] grid [0:htq_pkg::MaxSide*htq_pkg::MaxSide-1];
  height_result_t     expected_heights[$];

  function automatic logic signed [63:0] corner(longint cx, longint cz);
    if (cx >= htq_pkg::MaxSide || cz >= htq_pkg::MaxSide) return 0;
    return grid[cx * htq_pkg::MaxSide + cz];
  endfunction

  function automatic height_result_t query_height(logic signed [31:0] wx,
                                                  logic signed [31:0] wz);
    height_result_t r;
    longint vc, lx, lz, sx, sz, gx, gz, fx, fz, s, h;
    vc = vtx_count;
    if (vc < 2) vc = 2;
    if (vc > htq_pkg::MaxSide) vc = htq_pkg::MaxSide;
    lx = longint'(wx) - longint'(org_x);
    lz = longint'(wz) - longint'(org_z);
    sx = lx * longint'(inv_cell);
    sz = lz * longint'(inv_cell);
    r = '0;
    if (sx < 0 || sz < 0) return r;
    gx = sx >>> 32;
    gz = sz >>> 32;
    if (gx >= vc - 1 || gz >= vc - 1) return r;
    fx = (sx >>> 16) & 64'hFFFF;
    fz = (sz >>> 16) & 64'hFFFF;
    if (fx + fz <= 65536)
      s = corner(gx, gz) * (65536 - fx - fz) + corner(gx + 1, gz) * fx
          + corner(gx, gz + 1) * fz;
    else
      s = corner(gx + 1, gz) * (65536 - fz) + corner(gx + 1, gz + 1) * (fx + fz - 65536)
          + corner(gx, gz + 1) * (65536 - fx);
    h = s >>> 16;
    r.height = h[15:0];
    r.in_grid = 1'b1;
    return r;
  endfunction

  always @(posedge clk) begin
    height_result_t got, exp_r;
    if (rst) begin
      org_x <= 0;
      org_z <= 0;
      vtx_count <= 9'd256;
      inv_cell <= 24'd65536;
      fail_count <= 0;
      expected_heights.delete();
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          htq_pkg::RegOriginX: org_x <= cfg_data;
          htq_pkg::RegOriginZ: org_z <= cfg_data;
          htq_pkg::RegVertexCount: vtx_count <= cfg_data[8:0];
          htq_pkg::RegInvCell: inv_cell <= cfg_data[23:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == htq_pkg::KindWrite)
          grid[s_axis_tdata[7:0] * htq_pkg::MaxSide + s_axis_tdata[15:8]] =
              s_axis_tdata[31:16];
        else
          expected_heights.push_back(query_height(s_axis_tdata[63:32], s_axis_tdata[95:64]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.height = m_axis_tdata;
        got.in_grid = m_axis_tuser;
        if (expected_heights.size() == 0) begin
          $display("%0t: unexpected result height=%h inside=%b", $time, got.height,
                   got.in_grid);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_heights.pop_front();
          if (got !== exp_r) begin
            $display("%0t: mismatch expected height=%h inside=%b actual height=%h inside=%b",
                     $time, exp_r.height, exp_r.in_grid, got.height, got.in_grid);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= expected_heights.size();
    end
  end
endmodule

/* sim/tb_heightmap_triangle_height_query.sv */
`timescale 1ns / 100ps
module tb_heightmap_triangle_height_query;
  logic        clk = 0;
  logic        rst = 1;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int          fail_count;
  int          pending;
  int          idle_cycles = 0;
  bit          no_idle = 0;
  bit          hold_off = 0;
  int          vc_now;
  int          inv_now;

  always #1 clk = ~clk;

  heightmap_triangle_height_query DUT (.*);

  htq_checker checker_i (.*);

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("[heightmap_triangle_height_query] ERROR");
      $finish;
    end
  end

  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        m_axis_tready <= 0;
        repeat (300) @(negedge clk);
        hold_off = 0;
      end else if (!no_idle && $urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 18);
        m_axis_tready <= 0;
        repeat (n) @(negedge clk);
      end
      m_axis_tready <= 1;
    end
  end

  task automatic send(bit kind, logic [95:0] data);
    int n;
    if (!no_idle && $urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 18);
      s_axis_tvalid <= 0;
      repeat (n) @(negedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= kind;
    s_axis_tdata <= data;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_height(int cx, int cz, logic [15:0] hv);
    send(htq_pkg::KindWrite, {64'h0, hv, cz[7:0], cx[7:0]});
  endtask

  task automatic query(logic [31:0] wx, logic [31:0] wz);
    send(htq_pkg::KindQuery, {wz, wx, $urandom_range(0, 65535) & 32'hFFFF_FFFF});
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    int n;
    s_axis_tvalid <= 0;
    n = 0;
    while (pending != 0 && n < 20000) begin
      @(negedge clk);
      n++;
    end
    repeat (12) @(negedge clk);
  endtask

  task automatic set_grid(int vc, int inv, logic [31:0] ox, logic [31:0] oz, int fill = 0);
    int w;
    drain();
    write_reg(htq_pkg::RegOriginX, ox);
    write_reg(htq_pkg::RegOriginZ, oz);
    write_reg(htq_pkg::RegVertexCount, vc);
    write_reg(htq_pkg::RegInvCell, inv);
    cfg_valid <= 0;
    vc_now = vc < 2 ? 2 : (vc > htq_pkg::MaxSide ? htq_pkg::MaxSide : vc);
    inv_now = inv;
    w = (fill > 0) ? fill : vc_now;
    for (int x = 0; x < w; x++)
      for (int z = 0; z < w; z++)
        write_height(x, z, 16'($urandom()));
  endtask

  task automatic random_query(logic [31:0] ox, logic [31:0] oz);
    longint cx, cz, fx, fz;
    if ($urandom_range(0, 4) == 0) begin
      query($urandom(), $urandom());
    end else begin
      cx = $urandom_range(0, vc_now - 1);
      cz = $urandom_range(0, vc_now - 1);
      fx = $urandom_range(0, 65535);
      fz = $urandom_range(0, 65535);
      query(32'(ox + ((((cx << 32) + (fx << 16)) / inv_now) & 64'hFFFF_FFFF)),
            32'(oz + ((((cz << 32) + (fz << 16)) / inv_now) & 64'hFFFF_FFFF)));
    end
  endtask

  initial begin
    logic [31:0] ox, oz;
    repeat (6) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    set_grid(2, 65536, 0, 0);
    write_height(0, 0, 16'h7FFF);
    write_height(1, 0, 16'h8000);
    write_height(0, 1, 16'h7FFF);
    write_height(1, 1, 16'h8000);
    query(0, 0);
    query(32'h0000_FFFF, 32'h0000_FFFF);
    query(32'h0000_8000, 32'h0000_8000);
    query(32'h0000_C000, 32'h0000_8000);
    query(32'h0001_0000, 0);
    query(32'hFFFF_FFFF, 0);
    query(32'h7FFF_FFFF, 32'h8000_0000);
    query(32'h8000_0000, 32'h7FFF_FFFF);
    write_height(255, 255, 16'h1234);
    set_grid(1, 16777215, 32'h8000_0000, 32'h7FFF_FFFF);
    query(32'h8000_0000, 32'h7FFF_FFFF);
    query(32'h8000_0100, 32'h7FFF_FFFF);
    // With a unit scale every query that falls inside this grid lands in the first cell.
    set_grid(300, 1, 32'hFFFF_0000, 32'h0001_0000, 2);
    query(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    hold_off = 1;
    for (int i = 0; i < 40; i++) random_query(32'hFFFF_0000, 32'h0001_0000);
    for (int phase = 0; phase < 6; phase++) begin
      ox = $urandom();
      oz = $urandom();
      set_grid($urandom_range(2, 12), $urandom_range(1, 16777215) | (phase << 16), ox, oz);
      if (phase == 5) no_idle = 1;
      for (int i = 0; i < 110; i++) begin
        if ($urandom_range(0, 9) == 0)
          write_height($urandom_range(0, vc_now - 1), $urandom_range(0, vc_now - 1),
                       16'($urandom()));
        else
          random_query(ox, oz);
      end
    end
    write_height(255, 0, 16'hFFFF);
    drain();
    if (fail_count == 0 && pending == 0)
      $display("[heightmap_triangle_height_query] OK");
    else
      $display("[heightmap_triangle_height_query] ERROR");
    $finish;
  end
endmodule
